[hdl/gneg_pkg.sv]
// Shared types and constants for the grid neighbour edge generator.
// No dependencies; imported by every module of the block.
package gneg_pkg;

    // Field widths
    localparam int INDEX_W = 16;
    localparam int DIM_W   = 9;
    localparam int GREY_W  = 8;
    localparam int COST_W  = 10;

    // Map dimension limit and neighbour count
    localparam logic [DIM_W-1:0] DIM_MAX = 9'd256;
    localparam int NB_COUNT = 8;
    localparam int NB_CNT_W = 4;

    // Neighbour order: straight moves first, then diagonals
    localparam logic [2:0] NB_LEFT       = 3'd0;
    localparam logic [2:0] NB_RIGHT      = 3'd1;
    localparam logic [2:0] NB_UP         = 3'd2;
    localparam logic [2:0] NB_DOWN       = 3'd3;
    localparam logic [2:0] NB_UP_LEFT    = 3'd4;
    localparam logic [2:0] NB_UP_RIGHT   = 3'd5;
    localparam logic [2:0] NB_DOWN_LEFT  = 3'd6;
    localparam logic [2:0] NB_DOWN_RIGHT = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;

    // Request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] cell_index;
        logic [GREY_W-1:0]  pixel_value;
    } req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] neighbor_index;
        logic [COST_W-1:0]  edge_cost;
        logic               no_edge;
        logic               last;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       write;
        logic       div_start;
        logic       issue;
        logic [2:0] nb_sel;
        logic       flush;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_map;
        logic div_done;
    } dp_status_t;

endpackage

[hdl/grid_neighbor_edge_generator_top.sv]
// Top level of the grid neighbour edge generator: controller plus datapath.
// Depends on gneg_pkg, gneg_ctrl, gneg_dp (which holds gneg_div).
//
// Usage:
//   Requests are accepted when start is high and busy is low. A write request
//   (kind 0) stores one grey level in the cost map; busy stays low.
//   A query request (kind 1) raises busy and yields one to eight results, each
//   shown for one cycle with result_valid high; the last has result.last set.
//   A query with no walkable neighbour, or a node off the map, yields a single
//   no_edge result.
//   Steps of a query: a range check, the bit-serial divider that splits the node
//   into row and column, a hand-over, the neighbour scan (one cost map read per
//   neighbour through the single memory port) and a final step; an off-map node
//   goes from the range check straight to the final step.
//   The last result appears in the cycle busy drops.
//   The receiver cannot stall; results are taken as shown.
//   Configuration (map_width index 0, map_height index 1) is written through
//   cfg_valid/cfg_ready, always ready; write only while idle.
//   Reset sets both dimensions to 256 and clears all control state. The cost
//   map is not cleared and must be written before it is read.
module grid_neighbor_edge_generator_top
    import gneg_pkg::*;
#(
    parameter int PIXEL_COUNT = 65536
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             request,
    output logic             result_valid,
    output rsp_t             result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       start_ok;

    assign cfg_ready = 1'b1;
    assign start_ok  = start && !busy;

    gneg_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_ok),
        .kind   (request.kind),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    gneg_dp #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .request      (request),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef ASSERT_OFF
    // Results only come out of a running query
    a_result_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe outside a query");

    // The final result coincides with the return to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy)
        else $error("last result while still busy");

    // A no_edge result is always the only and final one
    a_no_edge_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.no_edge |-> result.last)
        else $error("no_edge result not marked last");

    // An accepted query makes the block busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.kind == KIND_QUERY |=> busy)
        else $error("query accepted without going busy");
`endif

endmodule

[hdl/gneg_div.sv]
// Restoring divider, one quotient bit per cycle: splits a node index by the map width.
// Depends on gneg_pkg.
module gneg_div
    import gneg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [INDEX_W-1:0] dividend,
    input  logic [DIM_W-1:0]   divisor,
    output logic [INDEX_W-1:0] quotient,
    output logic [DIM_W-1:0]   remainder,
    output logic               done
);

    localparam int CNT_W = $clog2(INDEX_W);

    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [INDEX_W-1:0] quo_reg, quo_next;
    logic [DIM_W-1:0]   rem_reg, rem_next;
    logic [DIM_W:0]     trial;
    logic [DIM_W:0]     diff;
    logic               ge;

    // One shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[INDEX_W-1]};
        diff      = trial - {1'b0, divisor};
        ge        = trial >= {1'b0, divisor};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[INDEX_W-2:0], ge};
            rem_next = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(INDEX_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

[hdl/gneg_dp.sv]
// Datapath: config registers, cost map memory, neighbour address and cost, result register.
// Depends on gneg_pkg and gneg_div.
module gneg_dp
    import gneg_pkg::*;
#(
    parameter int PIXEL_COUNT = 65536
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       status,
    input  req_t             request,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_data,
    output logic             result_valid,
    output rsp_t             result
);

    localparam int ADDR_W = $clog2(PIXEL_COUNT);

    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [DIM_W-1:0]   w_reg, h_reg;
    logic [INDEX_W-1:0] node_reg;
    logic [GREY_W-1:0]  cost_map [PIXEL_COUNT];
    logic [GREY_W-1:0]  rd_data_reg;
    logic               rd_valid_reg, rd_valid_next;
    logic [INDEX_W-1:0] rd_index_reg;
    logic               rd_diag_reg;
    logic               pend_valid_reg, pend_valid_next;
    rsp_t               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg, out_next;

    logic [INDEX_W-1:0] quo;
    logic [DIM_W-1:0]   rem;
    logic               div_done;
    logic [2*DIM_W-1:0] area;
    logic [DIM_W-1:0]   w_clamp, h_clamp;
    logic               x_gt0, x_lt, y_gt0, y_lt, ok_sel;
    logic               go_up, go_down, go_left, go_right;
    logic [17:0]        nb;
    logic               in_store, wr_ok, hit;
    logic [DIM_W-1:0]   base;
    logic [COST_W-1:0]  cost;
    rsp_t               hit_rsp;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_MAX;
            height_reg <= DIM_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAP_WIDTH:  width_reg  <= cfg_data;
                REG_MAP_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign w_clamp = (width_reg > DIM_MAX) ? DIM_MAX : width_reg;
    assign h_clamp = (height_reg > DIM_MAX) ? DIM_MAX : height_reg;

    // Capture query node and dimensions
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            node_reg <= request.cell_index;
            w_reg    <= w_clamp;
            h_reg    <= h_clamp;
        end
    end

    // Node inside map and store; zero dimension gives zero area
    assign area = w_reg * h_reg;

    always_comb
    begin
        status.in_map   = ({2'b0, node_reg} < area)
                          && (32'(node_reg) < 32'(PIXEL_COUNT));
        status.div_done = div_done;
    end

    gneg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (node_reg),
        .divisor   (w_reg),
        .quotient  (quo),
        .remainder (rem),
        .done      (div_done)
    );

    // Boundary flags from column and row
    assign x_gt0 = rem != '0;
    assign x_lt  = ({1'b0, rem} + 10'd1) < {1'b0, w_reg};
    assign y_gt0 = quo != '0;
    assign y_lt  = ({1'b0, quo} + 17'd1) < 17'(h_reg);

    // Neighbour selection
    always_comb
    begin
        go_up    = 1'b0;
        go_down  = 1'b0;
        go_left  = 1'b0;
        go_right = 1'b0;
        unique case (cmd.nb_sel)
            NB_LEFT:       go_left = 1'b1;
            NB_RIGHT:      go_right = 1'b1;
            NB_UP:         go_up = 1'b1;
            NB_DOWN:       go_down = 1'b1;
            NB_UP_LEFT:    begin go_up = 1'b1;   go_left = 1'b1;  end
            NB_UP_RIGHT:   begin go_up = 1'b1;   go_right = 1'b1; end
            NB_DOWN_LEFT:  begin go_down = 1'b1; go_left = 1'b1;  end
            NB_DOWN_RIGHT: begin go_down = 1'b1; go_right = 1'b1; end
            default: ;
        endcase
        ok_sel = (!go_left || x_gt0) && (!go_right || x_lt)
                 && (!go_up || y_gt0) && (!go_down || y_lt);
        nb = 18'(node_reg)
             + (go_down ? 18'(w_reg) : 18'd0) - (go_up ? 18'(w_reg) : 18'd0)
             + (go_right ? 18'd1 : 18'd0) - (go_left ? 18'd1 : 18'd0);
        in_store = 32'(nb[16:0]) < 32'(PIXEL_COUNT);
    end

    assign wr_ok = 32'(request.cell_index) < 32'(PIXEL_COUNT);

    // Single-port cost map: write on a write request, registered read on issue
    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_ok)
            cost_map[ADDR_W'(32'(request.cell_index))] <= request.pixel_value;
        else if (cmd.issue)
            rd_data_reg <= cost_map[ADDR_W'(32'(nb[16:0]))];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_index_reg <= nb[INDEX_W-1:0];
            rd_diag_reg  <= cmd.nb_sel[2];
        end
    end

    assign rd_valid_next = cmd.issue && ok_sel && in_store;

    // Edge cost: (256 - grey) times 2 or 3
    assign base = DIM_MAX - {1'b0, rd_data_reg};
    assign cost = rd_diag_reg ? (COST_W'({base, 1'b0}) + COST_W'(base))
                              : COST_W'({base, 1'b0});
    assign hit  = rd_valid_reg && (rd_data_reg != '0);

    always_comb
    begin
        hit_rsp.neighbor_index = rd_index_reg;
        hit_rsp.edge_cost      = cost;
        hit_rsp.no_edge        = 1'b0;
        hit_rsp.last           = 1'b0;
    end

    // One edge held back so the final one can be marked last
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = 1'b0;
        out_next        = pend_reg;
        if (cmd.load)
            pend_valid_next = 1'b0;
        else if (hit)
        begin
            out_valid_next  = pend_valid_reg;
            pend_valid_next = 1'b1;
            pend_next       = hit_rsp;
        end
        else if (cmd.flush)
        begin
            out_valid_next = 1'b1;
            if (pend_valid_reg)
                out_next.last = 1'b1;
            else
            begin
                out_next.neighbor_index = '0;
                out_next.edge_cost      = '0;
                out_next.no_edge        = 1'b1;
                out_next.last           = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= rd_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[hdl/gneg_ctrl.sv]
// Controller: sequences range check, divide, neighbour scan and final result.
// Depends on gneg_pkg.
module gneg_ctrl
    import gneg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       kind,
    output logic       busy,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RANGE = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [NB_CNT_W-1:0] k_reg, k_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.nb_sel = k_reg[2:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_QUERY)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_RANGE;
                    end
                    else
                        cmd.write = 1'b1;
                end
            end
            S_RANGE:
            begin
                if (status.in_map)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    state_next = S_FLUSH;
            end
            S_DIV:
            begin
                k_next = '0;
                if (status.div_done)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (k_reg == NB_CNT_W'(NB_COUNT))
                    state_next = S_FLUSH;
                else
                begin
                    cmd.issue = 1'b1;
                    k_next    = k_reg + 1'b1;
                end
            end
            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule

[tb/tb_grid_neighbor_edge_generator_top.sv]
// Self-checking testbench for grid_neighbor_edge_generator_top: a predictor of the
// eight-connected edge list, checked result by result against the block's outputs.
// Depends on gneg_pkg and the RTL under hdl/; needs no files or arguments.
module tb_grid_neighbor_edge_generator_top;
    import gneg_pkg::*;

    localparam int PIX_COUNT     = 65536;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    req_t             request   = '0;
    logic             result_valid;
    rsp_t             result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = REG_MAP_WIDTH;
    logic [DIM_W-1:0] cfg_data  = '0;

    // Requests waiting to be issued, and edges still owed by the block
    req_t pending_reqs [$];
    rsp_t expected_edges [$];

    // Predictor state: grey levels as accepted, plus shadow of the dimension registers
    logic [GREY_W-1:0] grey_map [0:PIX_COUNT-1];
    logic [DIM_W-1:0]  width_reg  = DIM_MAX;
    logic [DIM_W-1:0]  height_reg = DIM_MAX;

    // Generator view: cells that will have been written once the queue drains
    bit planned_set [0:PIX_COUNT-1];
    int gen_w;
    int gen_h;
    int gen_items;
    int gen_queries;

    bit steady;
    int mismatch_cnt;
    int cycle_cnt;

    grid_neighbor_edge_generator_top #(
        .PIXEL_COUNT (PIX_COUNT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Expected edges of one query, in left, right, up, down, diagonals order
    function automatic void predict_edges(input logic [INDEX_W-1:0] node);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned base;
        int unsigned nb [NB_COUNT];
        bit          ok [NB_COUNT];
        rsp_t        found [NB_COUNT];
        rsp_t        lone;
        int          n;
        lone         = '0;
        lone.no_edge = 1'b1;
        lone.last    = 1'b1;
        w = (width_reg > DIM_MAX) ? DIM_MAX : width_reg;
        h = (height_reg > DIM_MAX) ? DIM_MAX : height_reg;
        if (w == 0 || h == 0 || node >= w * h || node >= PIX_COUNT)
        begin
            expected_edges.push_back(lone);
            return;
        end
        x = node % w;
        y = node / w;
        ok[NB_LEFT]       = x > 0;                      nb[NB_LEFT]       = node - 1;
        ok[NB_RIGHT]      = x + 1 < w;                  nb[NB_RIGHT]      = node + 1;
        ok[NB_UP]         = y > 0;                      nb[NB_UP]         = node - w;
        ok[NB_DOWN]       = y + 1 < h;                  nb[NB_DOWN]       = node + w;
        ok[NB_UP_LEFT]    = ok[NB_UP] && ok[NB_LEFT];    nb[NB_UP_LEFT]    = node - w - 1;
        ok[NB_UP_RIGHT]   = ok[NB_UP] && ok[NB_RIGHT];   nb[NB_UP_RIGHT]   = node - w + 1;
        ok[NB_DOWN_LEFT]  = ok[NB_DOWN] && ok[NB_LEFT];  nb[NB_DOWN_LEFT]  = node + w - 1;
        ok[NB_DOWN_RIGHT] = ok[NB_DOWN] && ok[NB_RIGHT]; nb[NB_DOWN_RIGHT] = node + w + 1;
        n = 0;
        for (int i = 0; i < NB_COUNT; i++)
        begin
            // off-map, beyond the store or black: no edge
            if (ok[i] && nb[i] < PIX_COUNT && grey_map[nb[i]] != 0)
            begin
                base = 256 - grey_map[nb[i]];
                found[n] = '0;
                found[n].neighbor_index = INDEX_W'(nb[i]);
                found[n].edge_cost = COST_W'((i < NB_UP_LEFT) ? base * 2 : base * 3);
                n++;
            end
        end
        if (n == 0)
            expected_edges.push_back(lone);
        else
        begin
            found[n-1].last = 1'b1;
            for (int i = 0; i < n; i++)
                expected_edges.push_back(found[i]);
        end
    endfunction

    // Request driver: presents the oldest pending request, idling at random unless steady
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 35))
            begin
                start   <= 1'b1;
                request <= pending_reqs[0];
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: config shadow, result check, prediction on each accepted request
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MAP_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_MAP_HEIGHT)
                    height_reg = cfg_data;
            end
            if (result_valid)
            begin
                if (expected_edges.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: idx %0d cost %0d none %0d last %0d",
                                 result.neighbor_index, result.edge_cost,
                                 result.no_edge, result.last);
                end
                else
                begin
                    want = expected_edges.pop_front();
                    if (result.neighbor_index !== want.neighbor_index ||
                        result.edge_cost !== want.edge_cost ||
                        result.no_edge !== want.no_edge || result.last !== want.last)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"mismatch: expected idx %0d cost %0d none %0d last %0d,",
                                      " got idx %0d cost %0d none %0d last %0d"},
                                     want.neighbor_index, want.edge_cost,
                                     want.no_edge, want.last,
                                     result.neighbor_index, result.edge_cost,
                                     result.no_edge, result.last);
                    end
                end
            end
            if (start && !busy)
            begin
                void'(pending_reqs.pop_front());
                if (request.kind == KIND_WRITE)
                    grey_map[request.cell_index] = request.pixel_value;
                else
                    predict_edges(request.cell_index);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Grey level biased towards black, white and the darkest walkable level
    function automatic int pick_grey();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 0;
        if (r == 2)
            return 255;
        if (r == 3)
            return 1;
        return $urandom_range(0, 255);
    endfunction

    // Coordinate biased towards the map border
    function automatic int pick_coord(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 0;
        if (r < 4)
            return span - 1;
        return $urandom_range(0, span - 1);
    endfunction

    task automatic queue_write(input int idx, input int grey);
        req_t r;
        r.kind        = KIND_WRITE;
        r.cell_index  = INDEX_W'(idx);
        r.pixel_value = GREY_W'(grey);
        pending_reqs.push_back(r);
        planned_set[idx] = 1'b1;
        gen_items++;
    endtask

    // Query a node, first writing any in-map neighbour not yet written, rewriting others at random
    task automatic queue_query(input int node, input int rewrite_pct);
        req_t r;
        int   x;
        int   y;
        int   nx;
        int   ny;
        if (gen_w != 0 && gen_h != 0 && node < gen_w * gen_h)
        begin
            x = node % gen_w;
            y = node / gen_w;
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++)
                begin
                    nx = x + dx;
                    ny = y + dy;
                    if ((dx != 0 || dy != 0) && nx >= 0 && nx < gen_w && ny >= 0 &&
                        ny < gen_h && (!planned_set[ny * gen_w + nx] ||
                        $urandom_range(0, 99) < rewrite_pct))
                        queue_write(ny * gen_w + nx, pick_grey());
                end
        end
        r.kind        = KIND_QUERY;
        r.cell_index  = INDEX_W'(node);
        r.pixel_value = GREY_W'($urandom_range(0, 255));
        pending_reqs.push_back(r);
        gen_items++;
        gen_queries++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DIM_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_dims(input int w_raw, input int h_raw);
        write_reg(REG_MAP_WIDTH, w_raw);
        write_reg(REG_MAP_HEIGHT, h_raw);
        gen_w = (w_raw > 256) ? 256 : w_raw;
        gen_h = (h_raw > 256) ? 256 : h_raw;
    endtask

    // Drain all requests and edges, then let the block fall idle
    task automatic settle();
        while (pending_reqs.size() != 0 || expected_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly prepared queries, with stray writes and off-map queries mixed in
    task automatic run_random_phase(input int w_raw, input int h_raw, input bit no_gaps);
        int pick;
        set_dims(w_raw, h_raw);
        steady      = no_gaps;
        gen_items   = 0;
        gen_queries = 0;
        while (gen_items < 10 || gen_queries < 4)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 7)
                queue_write($urandom_range(0, PIX_COUNT - 1), pick_grey());
            else if (gen_w * gen_h == 0)
                queue_query($urandom_range(0, PIX_COUNT - 1), 0);
            else if (pick == 8 && gen_w * gen_h < PIX_COUNT)
                queue_query($urandom_range(gen_w * gen_h, PIX_COUNT - 1), 0);
            else
                queue_query(pick_coord(gen_h) * gen_w + pick_coord(gen_w),
                            $urandom_range(0, 40));
        end
        settle();
        steady = 1'b0;
    endtask

    initial
    begin
        int dir_grey [12];
        int dir_nodes [8];
        dir_grey  = '{255, 1, 0, 128, 0, 0, 17, 255, 64, 0, 99, 0};
        dir_nodes = '{0, 3, 5, 6, 8, 11, 12, 65535};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: 4 x 3 map, corners, interiors, a fully blocked node, off-map nodes
        set_dims(4, 3);
        for (int i = 0; i < 12; i++)
            queue_write(i, dir_grey[i]);
        for (int i = 0; i < 8; i++)
            queue_query(dir_nodes[i], 0);
        settle();

        // Random phases across narrow, tall, empty and saturated maps
        run_random_phase(7, 5, 1'b1);
        run_random_phase(1, 1, 1'b0);
        run_random_phase(256, 1, 1'b0);
        run_random_phase(1, 256, 1'b0);
        run_random_phase(0, 511, 1'b0);
        run_random_phase(511, 300, 1'b0);
        run_random_phase(16, 0, 1'b0);
        run_random_phase(3, 9, 1'b0);

        if (mismatch_cnt == 0 && expected_edges.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
hdl/gneg_pkg.sv
hdl/gneg_div.sv
hdl/gneg_dp.sv
hdl/gneg_ctrl.sv
hdl/grid_neighbor_edge_generator_top.sv
tb/tb_grid_neighbor_edge_generator_top.sv
